// ===== rtl/csf_pkg.sv =====
// package with types and constants for the charger supervisor
`default_nettype none
package csf_pkg;

   localparam int unsigned TicksWidth   = 20;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [TicksWidth-1:0]   TicksMax   = '1;
   localparam logic [TicksWidth-1:0]   LimitReset = TicksWidth'(43200);
   localparam logic [CsrAddrWidth-1:0] AddrLimit  = '0;

   typedef enum logic [2:0] {
      ST_OFF      = 3'd0,
      ST_READY    = 3'd1,
      ST_CHARGING = 3'd2,
      ST_PAUSED   = 3'd3,
      ST_ERROR    = 3'd4
   } state_type;

   typedef struct packed {
      logic power_good_pin;
      logic charge_pin;
      logic fault_valid;
      logic fault_serious;
      logic fault_temperature;
      logic chip_overheat;
      logic query_ok;
      logic secondary_overheat;
      logic battery_overvoltage;
   } req_type;

   typedef struct packed {
      logic [2:0] charger_state;
      logic       charging_indicator;
      logic       wireless_enable;
      logic       source_is_wireless;
      logic       on_charger;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/charger_supervisor_fsm.sv =====
// charger supervisor: pin edge tracking, fault flags, charge state machine
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle while the result side does not stall; the state update sits between the two registers
// a stalled result holds the input register, which then stalls the request side
// reset (synchronous): state off charger, flags clear, wireless enabled,
// charge counter zero, charge limit 43200 ticks
`default_nettype none
module charger_supervisor_fsm
   import csf_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_type                 req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_type                      rsp_data,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0]      prdata,
   output logic                         pready
);

   logic                  in_valid_ff;
   req_type               in_data_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   logic [TicksWidth-1:0] limit_ff;

   state_type             state_ff, state_in;
   logic                  prev_pg_ff, prev_cp_ff;
   logic                  power_active_ff, power_active_in;
   logic                  charging_power_ff, charging_power_in;
   logic                  summary_ff, summary_in;
   logic                  heat_ff, heat_in;
   logic                  serious_ff, serious_in;
   logic                  source_ff, source_in;
   logic                  wireless_ff, wireless_in;
   logic [TicksWidth-1:0] ticks_ff, ticks_in;

   logic                  advance;
   logic                  heat_fault;
   logic [TicksWidth-1:0] ticks_inc;
   logic                  overtime;
   logic                  error_hit;
   logic                  source_pre;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr == AddrLimit) ? CsrDataWidth'(limit_ff) : '0;

   // pin edges and fault report
   always_comb begin
      power_active_in   = power_active_ff;
      source_pre        = source_ff;
      charging_power_in = charging_power_ff;
      serious_in        = serious_ff;
      heat_fault        = heat_ff;
      if (in_data_ff.power_good_pin != prev_pg_ff) begin
         power_active_in = in_data_ff.power_good_pin;
         source_pre      = in_data_ff.power_good_pin;
      end
      if (in_data_ff.charge_pin != prev_cp_ff) begin
         charging_power_in = in_data_ff.charge_pin;
      end
      if (in_data_ff.fault_valid) begin
         serious_in = in_data_ff.fault_serious;
         heat_fault = in_data_ff.fault_temperature;
      end
      ticks_inc = (ticks_ff != TicksMax) ? ticks_ff + 1'b1 : ticks_ff;
      overtime  = summary_ff && (ticks_inc > limit_ff);
      error_hit = in_data_ff.secondary_overheat || in_data_ff.battery_overvoltage ||
                  serious_in || overtime;
   end

   // next state
   always_comb begin
      state_in = error_hit ? ST_ERROR : state_ff;
      unique case (state_in)
         ST_OFF: begin
            if (power_active_in) state_in = ST_READY;
         end
         ST_READY: begin
            if (!power_active_in) state_in = ST_OFF;
            else if (charging_power_in) state_in = ST_CHARGING;
         end
         ST_CHARGING: begin
            if (!charging_power_in) begin
               if (in_data_ff.query_ok && in_data_ff.chip_overheat) state_in = ST_PAUSED;
               else if (in_data_ff.query_ok) state_in = ST_READY;
            end else if (heat_fault) begin
               state_in = ST_PAUSED;
            end
         end
         ST_PAUSED: begin
            if (!heat_fault) state_in = ST_CHARGING;
         end
         ST_ERROR: begin
            state_in = ST_ERROR;
         end
         default: begin
            state_in = ST_ERROR;
         end
      endcase
   end

   // flag and counter updates
   always_comb begin
      state_type cur;
      cur         = error_hit ? ST_ERROR : state_ff;
      summary_in  = summary_ff;
      heat_in     = heat_fault;
      wireless_in = error_hit ? 1'b0 : wireless_ff;
      source_in   = error_hit ? 1'b1 : source_pre;
      ticks_in    = summary_ff ? ticks_inc : ticks_ff;
      unique case (cur)
         ST_READY: begin
            if (power_active_in && charging_power_in) begin
               summary_in = 1'b1;
               ticks_in   = '0;
            end
         end
         ST_CHARGING: begin
            if (!charging_power_in) begin
               if (in_data_ff.query_ok && in_data_ff.chip_overheat) begin
                  heat_in     = 1'b1;
                  wireless_in = 1'b0;
               end else if (in_data_ff.query_ok) begin
                  summary_in = 1'b0;
               end
            end else if (heat_fault) begin
               wireless_in = 1'b0;
            end
         end
         ST_PAUSED: begin
            if (!heat_fault) wireless_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         limit_ff          <= LimitReset;
         state_ff          <= ST_OFF;
         prev_pg_ff        <= 1'b0;
         prev_cp_ff        <= 1'b0;
         power_active_ff   <= 1'b0;
         charging_power_ff <= 1'b0;
         summary_ff        <= 1'b0;
         heat_ff           <= 1'b0;
         serious_ff        <= 1'b0;
         source_ff         <= 1'b0;
         wireless_ff       <= 1'b1;
         ticks_ff          <= '0;
      end else begin
         if (psel && penable && pwrite && (paddr == AddrLimit)) begin
            limit_ff <= pwdata[TicksWidth-1:0];
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff          <= state_in;
            prev_pg_ff        <= in_data_ff.power_good_pin;
            prev_cp_ff        <= in_data_ff.charge_pin;
            power_active_ff   <= power_active_in;
            charging_power_ff <= charging_power_in;
            summary_ff        <= summary_in;
            heat_ff           <= heat_in;
            serious_ff        <= serious_in;
            source_ff         <= source_in;
            wireless_ff       <= wireless_in;
            ticks_ff          <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff.charger_state      <= state_in;
         rsp_data_ff.charging_indicator <= summary_in;
         rsp_data_ff.wireless_enable    <= wireless_in;
         rsp_data_ff.source_is_wireless <= source_in;
         rsp_data_ff.on_charger         <= power_active_in;
      end
   end

`ifndef SYNTHESIS
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ERROR |=> state_ff == ST_ERROR)
      else $error("error state left");

   a_error_no_wireless: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ERROR |-> !wireless_ff)
      else $error("wireless power enabled in error state");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled with no item held");

   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("item processed without a result");
`endif

endmodule
`default_nettype wire
